>>> sv/mwo_pkg.sv
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared types and constants of the multi-waveform oscillator.
// ----------------------------------------------------------------------------
package mwo_pkg;

   localparam int unsigned PHASE_BITS_DEF      = 32;
   localparam int unsigned SINE_TABLE_BITS_DEF = 10;
   localparam int unsigned SAMPLE_BITS_DEF     = 16;

   localparam int unsigned CSR_INDEX_BITS = 4;
   localparam int unsigned CSR_DATA_BITS  = 32;
   localparam int unsigned INC_BITS       = 32;
   localparam int unsigned WAVE_BITS      = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WAVE_SEL  = 4'd0,
      CSR_PHASE_INC = 4'd1
   } csr_index_type;

   typedef enum logic [WAVE_BITS-1:0] {
      WAVE_SAW    = 2'd0,
      WAVE_TRI    = 2'd1,
      WAVE_SQUARE = 2'd2,
      WAVE_SINE   = 2'd3
   } wave_type;

   localparam wave_type              WAVE_RESET = WAVE_SAW;
   localparam logic [INC_BITS-1:0]   INC_RESET  = 32'd39370534;

   // quarter-wave table build, Q2.30
   localparam logic [63:0]  Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0]  Q30_HALF    = 64'd1 << 29;
   localparam logic [63:0]  PI_HALF_Q30 = 64'd1686629713;
   localparam int unsigned  SERIES_TERMS = 6;
   localparam int unsigned  SINE_DIVS [SERIES_TERMS] = '{156, 110, 72, 42, 20, 6};

endpackage

>>> sv/mwo_if.sv
// ----------------------------------------------------------------------------
// mwo_if
// Valid/ready channels of the oscillator: tick requests, sample responses
// and register writes.
// ----------------------------------------------------------------------------
interface mwo_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface mwo_rsp_if import mwo_pkg::*; #(
   parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface mwo_csr_if import mwo_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/mwo_sine_rom.sv
// ----------------------------------------------------------------------------
// mwo_sine_rom
// Quarter-wave sine ROM, 2^TABLE_BITS+1 entries, registered read.
// ----------------------------------------------------------------------------
module mwo_sine_rom import mwo_pkg::*; #(
   parameter int unsigned TABLE_BITS  = SINE_TABLE_BITS_DEF,
   parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [TABLE_BITS:0]   rd_addr,
   output logic [SAMPLE_BITS:0]  rd_data
);

   localparam int unsigned DEPTH = (1 << TABLE_BITS) + 1;

   typedef logic [SAMPLE_BITS:0] rom_type [DEPTH];

   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] e;
      for (int k = 0; k < DEPTH; k++) begin
         x  = (64'(k) * PI_HALF_Q30) >> TABLE_BITS;
         x2 = (x * x) >> 30;
         t  = Q30_ONE;
         for (int j = 0; j < SERIES_TERMS; j++) begin
            t = Q30_ONE - ((x2 * t) >> 30) / 64'(SINE_DIVS[j]);
         end
         s = (x * t) >> 30;
         e = (s * (64'd1 << (SAMPLE_BITS - 1)) + Q30_HALF) >> 30;
         rom[k] = e[SAMPLE_BITS:0];
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [SAMPLE_BITS:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= SINE_ROM[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/multi_waveform_oscillator_core.sv
// ----------------------------------------------------------------------------
// multi_waveform_oscillator_core
// Path: a request beat passes the stage-1 register, then the output register,
// before its response beat is valid; stage 1 waits under response backpressure.
// Throughput: one sample per cycle while the response side does not stall; the
// registered sine ROM read sets the two-stage depth, the phase add is combinational.
// Reset: phase, waveform select, increment and all valids take reset values; no clearing pass.
// ----------------------------------------------------------------------------
module multi_waveform_oscillator_core import mwo_pkg::*; #(
   parameter int unsigned PHASE_BITS      = PHASE_BITS_DEF,
   parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
   parameter int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   mwo_csr_if.sink   csr_ch,
   mwo_req_if.sink   req_ch,
   mwo_rsp_if.source rsp_ch
);

   localparam int unsigned VB       = SAMPLE_BITS + 2;
   localparam int unsigned TRI_BITS = SAMPLE_BITS + 1;
   localparam int unsigned SIN_BITS = SINE_TABLE_BITS + 2;
   localparam int unsigned EXT_BITS = (TRI_BITS > SIN_BITS) ? TRI_BITS : SIN_BITS;
   localparam int unsigned WIDE     = PHASE_BITS + EXT_BITS;

   localparam logic signed [VB-1:0]       H_V      = VB'(1) << (SAMPLE_BITS - 1);
   localparam logic signed [VB-1:0]       TWO_H_V  = VB'(1) << SAMPLE_BITS;
   localparam logic signed [VB-1:0]       FOUR_H_V = VB'(1) << (SAMPLE_BITS + 1);
   localparam logic [TRI_BITS-1:0]        H_Q      = TRI_BITS'(1) << (SAMPLE_BITS - 1);
   localparam logic [TRI_BITS-1:0]        THREE_H_Q = (TRI_BITS'(3)) << (SAMPLE_BITS - 1);
   localparam logic [SINE_TABLE_BITS:0]   TAB_N    = (SINE_TABLE_BITS+1)'(1) << SINE_TABLE_BITS;

   // configuration
   wave_type              sel_ff, sel_in;
   logic [INC_BITS-1:0]   inc_ff, inc_in;
   // accumulator
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   // stage 1: ROM read in flight
   logic                  s1_valid_ff, s1_valid_in;
   wave_type              s1_sel_ff, s1_sel_in;
   logic                  s1_neg_ff, s1_neg_in;
   logic signed [VB-1:0]  s1_wave_ff, s1_wave_in;
   // stage 2: output register
   logic                           out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0]  out_sample_ff, out_sample_in;

   logic                          req_fire;
   logic                          adv2;
   logic [PHASE_BITS-1:0]         phase_cur;
   logic [PHASE_BITS+INC_BITS-1:0] inc_wide;
   logic [WIDE-1:0]               ph_ext;
   logic [SAMPLE_BITS-1:0]        u_saw;
   logic [TRI_BITS-1:0]           u_tri;
   logic [SIN_BITS-1:0]           u_sin;
   logic [SINE_TABLE_BITS:0]      rom_addr;
   logic [SAMPLE_BITS:0]          rom_data;
   logic signed [VB-1:0]          v_sine;
   logic signed [VB-1:0]          v_pick;

   assign csr_ch.ready = 1'b1;

   assign adv2         = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || adv2;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign phase_cur = req_ch.restart ? '0 : phase_ff;
   assign inc_wide  = {{PHASE_BITS{1'b0}}, inc_ff};
   assign ph_ext    = {phase_cur, {EXT_BITS{1'b0}}};
   assign u_saw     = ph_ext[WIDE-1 -: SAMPLE_BITS];
   assign u_tri     = ph_ext[WIDE-1 -: TRI_BITS];
   assign u_sin     = ph_ext[WIDE-1 -: SIN_BITS];

   always_comb begin
      if (u_sin[SINE_TABLE_BITS]) begin
         rom_addr = TAB_N - {1'b0, u_sin[SINE_TABLE_BITS-1:0]};
      end else begin
         rom_addr = {1'b0, u_sin[SINE_TABLE_BITS-1:0]};
      end
   end

   mwo_sine_rom #(
      .TABLE_BITS  (SINE_TABLE_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_sine_rom (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   // config and accumulator
   always_comb begin
      sel_in   = sel_ff;
      inc_in   = inc_ff;
      phase_in = phase_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         if (csr_ch.index == CSR_WAVE_SEL) begin
            sel_in = wave_type'(csr_ch.data[WAVE_BITS-1:0]);
         end else if (csr_ch.index == CSR_PHASE_INC) begin
            inc_in = csr_ch.data[INC_BITS-1:0];
         end
      end
      if (req_fire) begin
         phase_in = phase_cur + inc_wide[PHASE_BITS-1:0];
      end
   end

   // stage 1: non-sine waves from the phase
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_sel_in   = s1_sel_ff;
      s1_neg_in   = s1_neg_ff;
      s1_wave_in  = s1_wave_ff;
      if (adv2) begin
         s1_valid_in = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_sel_in   = sel_ff;
         s1_neg_in   = u_sin[SIN_BITS-1];
         unique case (sel_ff)
            WAVE_SAW: begin
               s1_wave_in = $signed({2'b00, u_saw}) - H_V;
            end
            WAVE_TRI: begin
               if (u_tri < H_Q) begin
                  s1_wave_in = $signed({1'b0, u_tri});
               end else if (u_tri < THREE_H_Q) begin
                  s1_wave_in = TWO_H_V - $signed({1'b0, u_tri});
               end else begin
                  s1_wave_in = $signed({1'b0, u_tri}) - FOUR_H_V;
               end
            end
            WAVE_SQUARE: begin
               s1_wave_in = (!phase_cur[PHASE_BITS-1] && (|phase_cur)) ? H_V : -H_V;
            end
            WAVE_SINE: begin
               s1_wave_in = '0;
            end
            default: begin
               s1_wave_in = '0;
            end
         endcase
      end
   end

   // stage 2: sine sign, saturation, output register
   assign v_sine = s1_neg_ff ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
   assign v_pick = (s1_sel_ff == WAVE_SINE) ? v_sine : s1_wave_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (adv2) begin
         out_valid_in = 1'b1;
         if (v_pick > H_V - VB'(1)) begin
            out_sample_in = SAMPLE_BITS'(H_V - VB'(1));
         end else begin
            out_sample_in = v_pick[SAMPLE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= WAVE_RESET;
         inc_ff       <= INC_RESET;
         phase_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sel_ff       <= sel_in;
         inc_ff       <= inc_in;
         phase_ff     <= phase_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sel_ff     <= s1_sel_in;
      s1_neg_ff     <= s1_neg_in;
      s1_wave_ff    <= s1_wave_in;
      out_sample_ff <= out_sample_in;
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.sample = out_sample_ff;

endmodule

>>> sv/mwo_checker.sv
// ----------------------------------------------------------------------------
// mwo_checker
// Port-level checks of the oscillator core, bound to the top level.
// ----------------------------------------------------------------------------
module mwo_checker import mwo_pkg::*; #(
   parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_sample
);

   // nothing left in flight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // every accepted request beat must later show as a valid response beat
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##2 rsp_valid)
      else $error("response beat missing two cycles after request");

   // request side only stalls under response backpressure
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without response backpressure");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample)))
      else $error("stalled response beat changed");

endmodule

bind multi_waveform_oscillator_core mwo_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_mwo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_sample (rsp_ch.sample)
);
